/* hw/rtl/char_lcd_nibble_sequencer_defines.svh */
// assertion macros used by the back end of the lcd sequencer
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH

// property that must hold in the same cycle as its antecedent
`define CLNS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// property whose consequence is checked in the cycle after its antecedent
`define CLNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/clns_pkg.sv */
// types, constants and the init step table for the lcd nibble sequencer
package clns_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int HOLD_W      = 19;
  localparam int REG_W       = 18;
  localparam int STEP_W      = 5;

  localparam logic [REG_W-1:0] SHORT_HOLD_RESET = 18'd10;
  localparam logic [REG_W-1:0] LONG_HOLD_RESET  = 18'd50000;
  localparam logic [REG_W-1:0] POWER_HOLD_RESET = 18'd100000;

  localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd30;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] ROW1_BASE    = 8'h80;
  localparam logic [7:0] ROW2_BASE    = 8'hC0;

  typedef enum logic [2:0] {
    KIND_INIT  = 3'd0,
    KIND_CMD   = 3'd1,
    KIND_CHAR  = 3'd2,
    KIND_MOVE  = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_SHORT_HOLD = 2'd0,
    REG_LONG_HOLD  = 2'd1,
    REG_POWER_HOLD = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    HS_SHORT,
    HS_LONG,
    HS_POWER,
    HS_SETTLE
  } hold_sel_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  // one queued request as the back end sees it
  typedef struct packed {
    logic       is_init;
    logic       is_clear;
    logic       rs;
    logic [7:0] value;
  } desc_t;

  typedef struct packed {
    logic      [3:0] nib;
    logic            en;
    hold_sel_t       sel;
  } step_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // wake-up, 4-bit function set, clear, function set, mode, display, clear
  function automatic step_t init_step(input logic [STEP_W-1:0] idx);
    step_t s;
    case (idx)
      5'd0:  s = '{4'h3, 1'b0, HS_POWER};
      5'd1:  s = '{4'h3, 1'b1, HS_LONG};
      5'd2:  s = '{4'h3, 1'b0, HS_LONG};
      5'd3:  s = '{4'h3, 1'b0, HS_POWER};
      5'd4:  s = '{4'h3, 1'b1, HS_LONG};
      5'd5:  s = '{4'h3, 1'b0, HS_LONG};
      5'd6:  s = '{4'h3, 1'b0, HS_POWER};
      5'd7:  s = '{4'h3, 1'b1, HS_LONG};
      5'd8:  s = '{4'h3, 1'b0, HS_LONG};
      5'd9:  s = '{4'h2, 1'b1, HS_SHORT};
      5'd10: s = '{4'h2, 1'b0, HS_LONG};
      5'd11: s = '{4'h0, 1'b1, HS_SHORT};
      5'd12: s = '{4'h0, 1'b0, HS_LONG};
      5'd13: s = '{4'h1, 1'b1, HS_SHORT};
      5'd14: s = '{4'h1, 1'b0, HS_SETTLE};
      5'd15: s = '{4'h2, 1'b1, HS_SHORT};
      5'd16: s = '{4'h2, 1'b0, HS_LONG};
      5'd17: s = '{4'h8, 1'b1, HS_SHORT};
      5'd18: s = '{4'h8, 1'b0, HS_LONG};
      5'd19: s = '{4'h0, 1'b1, HS_SHORT};
      5'd20: s = '{4'h0, 1'b0, HS_LONG};
      5'd21: s = '{4'h6, 1'b1, HS_SHORT};
      5'd22: s = '{4'h6, 1'b0, HS_LONG};
      5'd23: s = '{4'h0, 1'b1, HS_SHORT};
      5'd24: s = '{4'h0, 1'b0, HS_LONG};
      5'd25: s = '{4'hC, 1'b1, HS_SHORT};
      5'd26: s = '{4'hC, 1'b0, HS_LONG};
      5'd27: s = '{4'h0, 1'b1, HS_SHORT};
      5'd28: s = '{4'h0, 1'b0, HS_LONG};
      5'd29: s = '{4'h1, 1'b1, HS_SHORT};
      5'd30: s = '{4'h1, 1'b0, HS_SETTLE};
      default: s = '{4'h0, 1'b0, HS_LONG};
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/clns_front.sv */
// front end: takes requests, drops those with no output, builds descriptors
module clns_front
  import clns_pkg::*;
(
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [2:0]    s_tuser,   // kind
  input  logic [15:0]   s_tdata,   // byte_value[7:0], row[9:8], column[15:10]
  input  queue_status_t q_status,
  output logic          push,
  output desc_t         push_desc
);

  logic [7:0] byte_value;
  logic [1:0] row;
  logic [5:0] column;
  logic [7:0] move_base;
  logic       keep;

  assign byte_value = s_tdata[7:0];
  assign row        = s_tdata[9:8];
  assign column     = s_tdata[15:10];

  assign s_tready = !q_status.full;

  assign move_base = (row == 2'd1) ? ROW1_BASE : ROW2_BASE;

  always_comb begin
    keep      = 1'b1;
    push_desc = '{1'b0, 1'b0, 1'b0, 8'h00};
    case (s_tuser)
      KIND_INIT: begin
        push_desc.is_init = 1'b1;
      end
      KIND_CMD: begin
        push_desc.value = byte_value;
      end
      KIND_CHAR: begin
        push_desc.rs    = 1'b1;
        push_desc.value = byte_value;
      end
      KIND_MOVE: begin
        // address wraps in 8 bits, column counted from 1
        keep            = (row == 2'd1) || (row == 2'd2);
        push_desc.value = move_base + {2'b00, column} - 8'd1;
      end
      KIND_CLEAR: begin
        push_desc.is_clear = 1'b1;
        push_desc.value    = CMD_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = s_tvalid && s_tready && keep;

endmodule

/* hw/rtl/clns_queue.sv */
// short request queue between the front end and the step sequencer
module clns_queue
  import clns_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  desc_t         push_desc,
  input  logic          pop,
  output desc_t         head,
  output queue_status_t status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  desc_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign head         = entries[rd_ptr];
  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

/* hw/rtl/clns_back.sv */
// back end: walks the pin-state steps of one request into the output register
module clns_back
  import clns_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  queue_status_t     q_status,
  input  desc_t             head,
  output logic              pop,
  input  logic [REG_W-1:0]  short_hold,
  input  logic [REG_W-1:0]  long_hold,
  input  logic [REG_W-1:0]  power_hold,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // reg_select[0], nibble[4:1], enable[5], hold[24:6]
  output logic              m_tlast
);

`include "char_lcd_nibble_sequencer_defines.svh"

  back_state_t       state;
  back_state_t       state_next;
  desc_t             desc;
  logic [STEP_W-1:0] step;
  step_t             cur;
  logic              step_last;
  logic              emit;
  logic [HOLD_W-1:0] hold_value;

  always_comb begin
    if (desc.is_init) begin
      cur = init_step(step);
    end else begin
      cur.nib = step[1] ? desc.value[3:0] : desc.value[7:4];
      cur.en  = !step[0];
      if (!step[0]) begin
        cur.sel = HS_SHORT;
      end else if (desc.is_clear && step[1]) begin
        cur.sel = HS_SETTLE;
      end else begin
        cur.sel = HS_LONG;
      end
    end
  end

  assign step_last = desc.is_init ? (step == INIT_LAST_STEP) : (step[1:0] == 2'd3);

  always_comb begin
    case (cur.sel)
      HS_SHORT:  hold_value = {1'b0, short_hold};
      HS_LONG:   hold_value = {1'b0, long_hold};
      HS_POWER:  hold_value = {1'b0, power_hold};
      HS_SETTLE: hold_value = {1'b0, long_hold} + {1'b0, short_hold};
      default:   hold_value = {1'b0, long_hold};
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (emit && step_last) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = (state == BK_IDLE) && !q_status.empty;
    emit = (state == BK_RUN) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        step <= '0;
      end else if (emit) begin
        step <= step + STEP_W'(1);
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      desc <= head;
    end
    if (emit) begin
      m_tdata <= {7'b0, hold_value, cur.en, cur.nib, desc.rs};
      m_tlast <= step_last;
    end
  end

  `CLNS_ASSERT_SAME(a_pop_idle, pop, state == BK_IDLE, "queue popped while a run is active")
  `CLNS_ASSERT_SAME(a_byte_steps, (state == BK_RUN) && !desc.is_init, step[4:2] == 3'd0,
                    "byte run beyond four steps")
  `CLNS_ASSERT_NEXT(a_last_ends, emit && step_last, state == BK_IDLE,
                    "run did not end on last step")
  `CLNS_ASSERT_NEXT(a_step_adv, emit && !step_last, step == $past(step) + STEP_W'(1),
                    "step counter did not advance")

endmodule

/* hw/rtl/char_lcd_nibble_sequencer.sv */
// top level of the 4-bit character lcd nibble sequencer
// path: a taken request goes into a queue entry, then the back end descriptor register, then m_tdata
// throughput: one pin state per cycle while m_tready is not held low; between runs the back end
//   spends an idle state popping the next request, and its step counter sets the run length
// a two-entry queue lets further requests be taken while a run is being played out
// reset: queue and sequencer empty, no output valid, holds 10, 50000 and 100000 units
module char_lcd_nibble_sequencer
  import clns_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [2:0]        s_tuser,   // kind
  input  logic [15:0]       s_tdata,   // byte_value[7:0], row[9:8], column[15:10]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // reg_select[0], nibble[4:1], enable[5], hold[24:6]
  output logic              m_tlast,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [REG_W-1:0]  cfg_data
);

  logic [REG_W-1:0] short_hold;
  logic [REG_W-1:0] long_hold;
  logic [REG_W-1:0] power_hold;
  queue_status_t    q_status;
  logic             push;
  logic             pop;
  desc_t            push_desc;
  desc_t            head;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_hold <= SHORT_HOLD_RESET;
      long_hold  <= LONG_HOLD_RESET;
      power_hold <= POWER_HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHORT_HOLD: short_hold <= cfg_data;
        REG_LONG_HOLD:  long_hold  <= cfg_data;
        REG_POWER_HOLD: power_hold <= cfg_data;
        default: ;
      endcase
    end
  end

  clns_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .q_status  (q_status),
    .push      (push),
    .push_desc (push_desc)
  );

  clns_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  clns_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .head       (head),
    .pop        (pop),
    .short_hold (short_hold),
    .long_hold  (long_hold),
    .power_hold (power_hold),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
